>>> rtl/core/prst_pkg.sv
`timescale 1ns / 1ps

package prst_pkg;

    localparam int CAPACITY   = 16;
    localparam int ELEM_BITS  = 16;
    localparam int PRIO_BITS  = 8;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    localparam int IN_DATA_BITS  = ((ELEM_BITS + PRIO_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = ELEM_BITS + PRIO_BITS + COUNT_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [ELEM_BITS-1:0] elem;
        logic [PRIO_BITS-1:0] prio;
    } t_entry;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [ELEM_BITS-1:0] elem;
        logic [PRIO_BITS-1:0] prio;
    } t_cell_ctl;

endpackage

>>> rtl/core/prst_cell.sv
`timescale 1ns / 1ps

module prst_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prst_pkg::t_cell_ctl i_ctl,
    input  prst_pkg::t_entry  i_prev_entry,
    input  logic              i_prev_keep,
    input  prst_pkg::t_entry  i_next_entry,
    output prst_pkg::t_entry  o_entry,
    output logic              o_keep
);
    import prst_pkg::*;

    logic                 r_valid;
    logic [ELEM_BITS-1:0] r_elem;
    logic [PRIO_BITS-1:0] r_prio;
    t_entry               n_entry;

    // entry stays put on push when it strictly outranks the new item
    assign o_keep  = r_valid && (r_prio > i_ctl.prio);
    assign o_entry = '{valid: r_valid, elem: r_elem, prio: r_prio};

    always_comb begin
        n_entry = o_entry;
        if (i_ctl.push) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_entry = '{valid: 1'b1, elem: i_ctl.elem, prio: i_ctl.prio};
                end else begin
                    n_entry = i_prev_entry;
                end
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_entry.valid;
        end
        r_elem <= n_entry.elem;
        r_prio <= n_entry.prio;
    end

endmodule

>>> rtl/core/priority_stack_core.sv
`timescale 1ns / 1ps

// Priority stack, 16 entries, kept sorted highest priority first; equal
// priorities leave last-in first-out.
// Input stream: s_axis transfer carries one operation. tuser[0] is the mode
// (0 push, 1 pop); tdata holds the element (low bits) and its priority.
// Output stream: m_axis transfer carries one result per operation. tdata
// reports front element, front priority, occupancy and empty flag after the
// operation; tuser holds the status (0 ok, 1 pop while empty, 2 push while
// full). A rejected push or pop leaves the contents untouched.
// The result is registered and valid in the cycle after the input transfer.
// Throughput: one operation per cycle while results are taken. The whole
// chain of cells updates together: each cell compares its priority with the
// new one and either holds, takes the new entry or takes its neighbor's entry.
// Reset (i_rst_n low, synchronous) empties the stack and drops any pending
// result.
// Stall: while a result waits with i_m_axis_tready low, s_axis tready is low
// and the stack contents hold; a new operation is taken in the same cycle
// the waiting result is transferred.
module priority_stack_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] elem_value, [23:16] prio_value
    input  logic [prst_pkg::IN_DATA_BITS-1:0] i_s_axis_tdata,
    // [0] mode
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] front_elem, [23:16] front_prio, [28:24] occupancy,
    // [29] is_empty, [31:30] zero
    output logic [prst_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]  o_m_axis_tuser
);
    import prst_pkg::*;

    t_entry    w_entry [CAPACITY];
    logic      w_keep  [CAPACITY];
    t_cell_ctl w_ctl;

    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_count;
    logic [1:0]            r_status;
    logic [COUNT_BITS-1:0] n_count;
    logic [1:0]            n_status;

    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [ELEM_BITS-1:0] w_in_elem;
    logic [PRIO_BITS-1:0] w_in_prio;
    logic [ELEM_BITS-1:0] w_front_elem;
    logic [PRIO_BITS-1:0] w_front_prio;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_in_elem = i_s_axis_tdata[ELEM_BITS-1:0];
    assign w_in_prio = i_s_axis_tdata[ELEM_BITS+PRIO_BITS-1:ELEM_BITS];

    // fullness and emptiness come straight off the chain ends
    assign w_full  = w_entry[CAPACITY-1].valid;
    assign w_empty = !w_entry[0].valid;

    always_comb begin
        w_ctl.push = w_accept && (i_s_axis_tuser == MODE_PUSH) && !w_full;
        w_ctl.pop  = w_accept && (i_s_axis_tuser == MODE_POP) && !w_empty;
        w_ctl.elem = w_in_elem;
        w_ctl.prio = w_in_prio;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_entry w_prev;
            t_entry w_next;
            logic   w_prev_keep;

            if (gi == 0) begin : g_head
                // virtual head always outranks: cell 0 loads the new item
                assign w_prev      = '{valid: 1'b1, elem: w_in_elem, prio: w_in_prio};
                assign w_prev_keep = 1'b1;
            end else begin : g_body
                assign w_prev      = w_entry[gi-1];
                assign w_prev_keep = w_keep[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign w_next = '{valid: 1'b0, elem: '0, prio: '0};
            end else begin : g_mid
                assign w_next = w_entry[gi+1];
            end

            prst_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev_entry (w_prev),
                .i_prev_keep  (w_prev_keep),
                .i_next_entry (w_next),
                .o_entry      (w_entry[gi]),
                .o_keep       (w_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (i_s_axis_tuser == MODE_PUSH) begin
            if (w_full) begin
                n_status = ST_PUSH_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_POP_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_status    <= ST_OK;
        end else begin
            if (w_accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_status    <= n_status;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // cells only change on an accepted op, so cell 0 shows the front
    // that belongs to the pending result
    assign w_front_elem = w_entry[0].valid ? w_entry[0].elem : '0;
    assign w_front_prio = w_entry[0].valid ? w_entry[0].prio : '0;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {{(OUT_DATA_BITS - OUT_RAW_BITS){1'b0}},
                              w_empty, r_count, w_front_prio, w_front_elem};

endmodule

>>> rtl/core/prst_checker.sv
`timescale 1ns / 1ps

module prst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [prst_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);
    import prst_pkg::*;

    localparam int OCC_LO = ELEM_BITS + PRIO_BITS;
    localparam int EMP_AT = OCC_LO + COUNT_BITS;

    logic [COUNT_BITS-1:0] w_occ;
    logic                  w_emp;
    assign w_occ = o_m_axis_tdata[EMP_AT-1:OCC_LO];
    assign w_emp = o_m_axis_tdata[EMP_AT];

    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // every input transfer yields a result on the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("no result after input transfer");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_emp == (w_occ == '0)))
        else $error("empty flag disagrees with occupancy");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_emp |-> (o_m_axis_tdata[OCC_LO-1:0] == '0))
        else $error("front not zero on empty stack");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_occ <= COUNT_BITS'(CAPACITY)) &&
            (o_m_axis_tuser != 2'd3))
        else $error("occupancy or status out of range");

endmodule

bind priority_stack_core prst_checker u_prst_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import prst_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_OPS    = 1750;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 4;

    typedef struct packed {
        logic                 mode;
        logic [ELEM_BITS-1:0] elem;
        logic [PRIO_BITS-1:0] prio;
    } op_t;

    typedef struct packed {
        logic [ELEM_BITS-1:0]  elem;
        logic [PRIO_BITS-1:0]  prio;
        logic [COUNT_BITS-1:0] occ;
        logic                  empty;
        logic [1:0]            status;
    } report_t;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_s_axis_tvalid;
    logic                      o_s_axis_tready;
    logic [IN_DATA_BITS-1:0]   i_s_axis_tdata;   // [15:0] elem, [23:16] prio
    logic                      i_s_axis_tuser;   // [0] mode
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready;
    logic [OUT_DATA_BITS-1:0]  o_m_axis_tdata;   // [15:0] elem, [23:16] prio, [28:24] occ, [29] empty
    logic [1:0]                o_m_axis_tuser;   // [1:0] status

    priority_stack_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Pending operations and the front reports they should produce
    op_t     op_queue[$];
    report_t front_reports[$];

    // Predicted stack, slot 0 is the front
    logic [ELEM_BITS-1:0] stk_elem[CAPACITY];
    logic [PRIO_BITS-1:0] stk_prio[CAPACITY];
    int                   stk_count;

    int  errors;
    int  ops_accepted;
    int  cycles;
    bit  in_taken;
    bit  hold_off;
    int  tx_gap;
    int  rx_stall;
    bit  tx_burst;
    bit  rx_burst;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one operation to the predicted stack and return the front report.
    function automatic report_t update_stack(input op_t op);
        report_t r;
        int      pos;
        r.status = ST_OK;
        if (op.mode == MODE_PUSH) begin
            if (stk_count >= CAPACITY) begin
                r.status = ST_PUSH_FULL;
            end else begin
                // skip only strictly higher priorities: ties go in front (LIFO)
                pos = 0;
                while (pos < stk_count && stk_prio[pos] > op.prio) pos++;
                for (int k = stk_count; k > pos; k--) begin
                    stk_elem[k] = stk_elem[k-1];
                    stk_prio[k] = stk_prio[k-1];
                end
                stk_elem[pos] = op.elem;
                stk_prio[pos] = op.prio;
                stk_count++;
            end
        end else begin
            if (stk_count == 0) begin
                r.status = ST_POP_EMPTY;
            end else begin
                for (int k = 0; k + 1 < stk_count; k++) begin
                    stk_elem[k] = stk_elem[k+1];
                    stk_prio[k] = stk_prio[k+1];
                end
                stk_count--;
            end
        end
        r.elem  = (stk_count > 0) ? stk_elem[0] : '0;
        r.prio  = (stk_count > 0) ? stk_prio[0] : '0;
        r.occ   = stk_count[COUNT_BITS-1:0];
        r.empty = (stk_count == 0);
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none while in a burst stretch.
    function automatic int pick_gap(input bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    function automatic op_t make_op(input logic mode, input int elem, input int prio);
        op_t op;
        op.mode = mode;
        op.elem = elem[ELEM_BITS-1:0];
        op.prio = prio[PRIO_BITS-1:0];
        return op;
    endfunction

    // Sender: holds an operation until its transfer, then may idle a while.
    always @(negedge i_clk) begin : sender
        op_t op;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_taken) begin
            if ($urandom_range(0, 99) == 0) tx_burst = !tx_burst;
            if (tx_gap > 0) begin
                tx_gap--;
                i_s_axis_tvalid <= 1'b0;
            end else if (op_queue.size() > 0) begin
                op = op_queue.pop_front();
                i_s_axis_tdata  <= {op.prio, op.elem};
                i_s_axis_tuser  <= op.mode;
                i_s_axis_tvalid <= 1'b1;
                tx_gap = pick_gap(tx_burst);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off when requested.
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) rx_burst = !rx_burst;
            i_m_axis_tready <= 1'b1;
            rx_stall = pick_gap(rx_burst);
        end
    end

    // Monitor: check the result transfer first, since any new expectation
    // belongs to a later result.
    always @(posedge i_clk) begin : monitor
        report_t got;
        report_t want;
        op_t     op;
        in_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.elem   = o_m_axis_tdata[15:0];
            got.prio   = o_m_axis_tdata[23:16];
            got.occ    = o_m_axis_tdata[28:24];
            got.empty  = o_m_axis_tdata[29];
            got.status = o_m_axis_tuser;
            if (front_reports.size() == 0) begin
                $error("result transfer with no operation outstanding");
                errors++;
            end else begin
                want = front_reports.pop_front();
                check_field("front_elem", want.elem,   got.elem);
                check_field("front_prio", want.prio,   got.prio);
                check_field("occupancy",  want.occ,    got.occ);
                check_field("is_empty",   want.empty,  got.empty);
                check_field("status",     want.status, got.status);
            end
        end
        if (in_taken) begin
            op.elem = i_s_axis_tdata[15:0];
            op.prio = i_s_axis_tdata[23:16];
            op.mode = i_s_axis_tuser;
            front_reports.push_back(update_stack(op));
            ops_accepted++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Long receiver hold-offs: the single result slot fills and the input
    // side must stall while the sender keeps offering.
    initial begin : hold_control
        int marks[2];
        marks[0] = 400;
        marks[1] = 1200;
        foreach (marks[i]) begin
            wait (ops_accepted >= marks[i]);
            @(posedge i_clk);
            hold_off = 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            hold_off = 1'b0;
        end
    end

    initial begin : stimulus
        int    generated;
        int    phase_len;
        int    push_pct;
        int    prio;
        logic  mode;

        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = MODE_PUSH;
        i_m_axis_tready = 1'b0;
        stk_count       = 0;
        errors          = 0;
        ops_accepted    = 0;
        cycles          = 0;
        in_taken        = 1'b0;
        hold_off        = 1'b0;
        tx_gap          = 0;
        rx_stall        = 0;
        tx_burst        = 1'b0;
        rx_burst        = 1'b0;

        // Directed: pop while empty (ignored fields all ones), extremes,
        // a run of equal priorities to show LIFO order among ties.
        op_queue.push_back(make_op(MODE_POP,  16'hFFFF, 8'hFF));
        op_queue.push_back(make_op(MODE_PUSH, 16'hFFFF, 8'hFF));
        op_queue.push_back(make_op(MODE_PUSH, 16'h0000, 8'h00));
        op_queue.push_back(make_op(MODE_PUSH, 16'h1111, 8'h80));
        op_queue.push_back(make_op(MODE_PUSH, 16'h2222, 8'h80));
        op_queue.push_back(make_op(MODE_PUSH, 16'h3333, 8'h80));
        op_queue.push_back(make_op(MODE_POP,  16'h0000, 8'h00));
        op_queue.push_back(make_op(MODE_POP,  16'h5A5A, 8'hA5));
        op_queue.push_back(make_op(MODE_PUSH, 16'hAAAA, 8'hFF));
        // four entries now; fill to capacity, then push while full
        for (int i = 0; i < 12; i++)
            op_queue.push_back(make_op(MODE_PUSH, 16'hC000 + i, $urandom_range(0, 255)));
        op_queue.push_back(make_op(MODE_PUSH, 16'hBEEF, 8'hFF));
        op_queue.push_back(make_op(MODE_PUSH, 16'h0001, 8'h00));

        // Random: phases biased toward push, pop or neither, so the stack
        // swings between full and empty many times.
        generated = 0;
        while (generated < RANDOM_OPS) begin
            phase_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: begin
                    push_pct = 85;
                end
                1: begin
                    push_pct = 15;
                end
                default: begin
                    push_pct = 50;
                end
            endcase
            for (int i = 0; i < phase_len; i++) begin
                mode = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
                // a narrow priority band makes ties common
                case ($urandom_range(0, 9))
                    0: prio = 0;
                    1: prio = 255;
                    2, 3: prio = $urandom_range(64, 67);
                    default: prio = $urandom_range(0, 255);
                endcase
                op_queue.push_back(make_op(mode, $urandom_range(0, 65535), prio));
                generated++;
            end
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || i_s_axis_tvalid || front_reports.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
